### rtl/ttifq_pkg.sv
// Shared types and constants for the thread-tagged instruction queue.
// Used by the controller, the datapath, the top level and the checker.
package ttifq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int ID_W      = 16;
    localparam int THR_W     = 2;
    localparam int THREADS   = 4;
    // Bits of the squash mask that are counted in one cycle.
    localparam int CHUNK     = 8;

    localparam logic [2:0] FN_ADD        = 3'd0;
    localparam logic [2:0] FN_REMOVE     = 3'd1;
    localparam logic [2:0] FN_PEEK       = 3'd2;
    localparam logic [2:0] FN_SQUASH_ALL = 3'd3;
    localparam logic [2:0] FN_SQUASH_ONE = 3'd4;

    typedef struct packed {
        logic capture;     // latch the input transaction, clear scratch state
        logic do_add;      // append at the tail
        logic do_head;     // read the head entry
        logic pop_head;    // with do_head: remove it
        logic do_squash;   // clear matching live bits, start counting
        logic squash_one;  // with do_squash: match only the selected thread
        logic cnt_step;    // count one chunk of the squash mask
        logic load_result; // move the finished result to the output register
    } ttifq_cmd_t;

    typedef struct packed {
        logic [2:0] func;        // captured operation code
        logic       count_done;  // current chunk is the last one
        logic       res_blocked; // output register still holds a result
    } ttifq_sts_t;

endpackage

### rtl/ttifq_ctrl.sv
// Controller state machine for the thread-tagged instruction queue.
// Depends on ttifq_pkg; drives commands into ttifq_dp.
module ttifq_ctrl
    import ttifq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ttifq_sts_t sts,
    output ttifq_cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COUNT, S_FINISH} state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.func == FN_SQUASH_ALL || sts.func == FN_SQUASH_ONE)
                begin
                    state_next = S_COUNT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_COUNT:
            begin
                if (sts.count_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.res_blocked)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = (state_reg == S_IDLE) && in_valid;
        cmd.do_add      = (state_reg == S_EXEC) && (sts.func == FN_ADD);
        cmd.do_head     = (state_reg == S_EXEC) &&
                          (sts.func == FN_REMOVE || sts.func == FN_PEEK);
        cmd.pop_head    = (sts.func == FN_REMOVE);
        cmd.do_squash   = (state_reg == S_EXEC) &&
                          (sts.func == FN_SQUASH_ALL || sts.func == FN_SQUASH_ONE);
        cmd.squash_one  = (sts.func == FN_SQUASH_ONE);
        cmd.cnt_step    = (state_reg == S_COUNT);
        cmd.load_result = (state_reg == S_FINISH) && !sts.res_blocked;
    end

endmodule

### rtl/ttifq_dp.sv
// Datapath of the thread-tagged instruction queue: id memory, tag and live
// bits, pointers, per-thread counts, squash counter and output register.
// Depends on ttifq_pkg; controlled by ttifq_ctrl.
module ttifq_dp
    import ttifq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ttifq_cmd_t        cmd,
    output ttifq_sts_t        sts,
    input  logic [2:0]        func,
    input  logic [ID_W-1:0]   inst_id,
    input  logic              inst_present,
    input  logic [THR_W-1:0]  thread_sel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CNT_W-1:0]  occupancy,
    output logic [ID_W-1:0]   head_id,
    output logic              head_present,
    output logic [THR_W-1:0]  head_thread,
    output logic [CNT_W-1:0]  squashed_count,
    output logic [CNT_W-1:0]  thread_count,
    output logic              error
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
    localparam int MASK_W = NCHUNK * CHUNK;
    localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PC_W   = $clog2(CHUNK + 1);

    // Captured transaction.
    logic [2:0]       func_reg;
    logic [ID_W-1:0]  id_reg;
    logic             pres_reg;
    logic [THR_W-1:0] thr_reg;

    // Queue state.
    logic [ID_W-1:0]  id_mem [DEPTH];
    logic [ID_W-1:0]  mem_q_reg;
    logic [THR_W-1:0] tag_reg [DEPTH];
    logic [DEPTH-1:0] live_reg, live_next;
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] tcnt_reg [THREADS];

    // Per-transaction scratch.
    logic             err_reg, hval_reg, hlive_reg;
    logic [THR_W-1:0] hthr_reg;
    logic [CNT_W-1:0] sq_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [CIDX_W-1:0] cidx_reg;

    // Output register.
    logic             ovld_reg;
    logic [CNT_W-1:0] occ_out_reg, sq_out_reg, tc_out_reg;
    logic [ID_W-1:0]  id_out_reg;
    logic             pres_out_reg, err_out_reg;
    logic [THR_W-1:0] thr_out_reg;

    logic             full, empty, wr_en, pop_en;
    logic [DEPTH-1:0] match;
    logic [PC_W-1:0]  chunk_cnt;
    logic [THR_W-1:0] head_tag;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign wr_en    = cmd.do_add && !full && pres_reg;
    assign pop_en   = cmd.do_head && cmd.pop_head && !empty;
    assign head_tag = tag_reg[head_reg];

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Every live entry is held, so the live bits alone bound the squash.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i] = live_reg[i] && (!cmd.squash_one || tag_reg[i] == thr_reg);
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (cmd.do_squash)
        begin
            live_next = live_reg & ~match;
        end
        if (pop_en)
        begin
            live_next[head_reg] = 1'b0;
        end
        if (wr_en)
        begin
            live_next[tail_reg] = 1'b1;
        end
    end

    always_comb
    begin
        chunk_cnt = '0;
        for (int i = 0; i < CHUNK; i++)
        begin
            chunk_cnt = chunk_cnt + PC_W'(mask_reg[i]);
        end
    end

    // Id memory and tags: written at the tail, head read registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[tail_reg] <= id_reg;
        end
        if (cmd.do_head)
        begin
            mem_q_reg <= id_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg[tail_reg] <= thr_reg;
        end
        if (cmd.capture)
        begin
            func_reg <= func;
            id_reg   <= inst_id;
            pres_reg <= inst_present;
            thr_reg  <= thread_sel;
        end
        if (cmd.do_head)
        begin
            hlive_reg <= live_reg[head_reg];
            hthr_reg  <= head_tag;
        end
        if (cmd.load_result)
        begin
            occ_out_reg  <= fill_reg;
            tc_out_reg   <= tcnt_reg[thr_reg];
            id_out_reg   <= (hval_reg && hlive_reg) ? mem_q_reg : '0;
            pres_out_reg <= hval_reg && hlive_reg;
            thr_out_reg  <= hval_reg ? hthr_reg : '0;
            sq_out_reg   <= sq_reg;
            err_out_reg  <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            for (int t = 0; t < THREADS; t++)
            begin
                tcnt_reg[t] <= '0;
            end
            err_reg  <= 1'b0;
            hval_reg <= 1'b0;
            sq_reg   <= '0;
            mask_reg <= '0;
            cidx_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            if (cmd.capture)
            begin
                err_reg  <= 1'b0;
                hval_reg <= 1'b0;
                sq_reg   <= '0;
            end
            if (cmd.do_add && full)
            begin
                err_reg <= 1'b1;
            end
            if (wr_en)
            begin
                tail_reg           <= next_slot(tail_reg);
                fill_reg           <= fill_reg + 1'b1;
                tcnt_reg[thr_reg]  <= tcnt_reg[thr_reg] + 1'b1;
            end
            if (cmd.do_head)
            begin
                hval_reg <= !empty;
                if (cmd.pop_head && empty)
                begin
                    err_reg <= 1'b1;
                end
            end
            if (pop_en)
            begin
                head_reg <= next_slot(head_reg);
                fill_reg <= fill_reg - 1'b1;
                if (tcnt_reg[head_tag] != '0)
                begin
                    tcnt_reg[head_tag] <= tcnt_reg[head_tag] - 1'b1;
                end
            end
            if (cmd.do_squash)
            begin
                mask_reg <= MASK_W'(match);
                cidx_reg <= '0;
            end
            else if (cmd.cnt_step)
            begin
                sq_reg   <= sq_reg + CNT_W'(chunk_cnt);
                mask_reg <= mask_reg >> CHUNK;
                cidx_reg <= cidx_reg + 1'b1;
            end
            if (cmd.load_result)
            begin
                ovld_reg <= 1'b1;
            end
            else if (ovld_reg && !out_stall)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    assign sts.func        = func_reg;
    assign sts.count_done  = (cidx_reg == CIDX_W'(NCHUNK - 1));
    assign sts.res_blocked = ovld_reg && out_stall;

    assign out_valid      = ovld_reg;
    assign occupancy      = occ_out_reg;
    assign head_id        = id_out_reg;
    assign head_present   = pres_out_reg;
    assign head_thread    = thr_out_reg;
    assign squashed_count = sq_out_reg;
    assign thread_count   = tc_out_reg;
    assign error          = err_out_reg;

endmodule

### rtl/thread_tagged_inst_fifo_squash.sv
// Top level of the thread-tagged instruction queue with squash.
// Depends on ttifq_pkg; instantiates ttifq_ctrl and ttifq_dp.
//
//   Channel  Handshake           Carries
//   input    in_valid/in_stall   func, inst_id, inst_present, thread_sel
//   output   out_valid/out_stall occupancy, head_id, head_present,
//                                head_thread, squashed_count, thread_count, error
//
// One transaction is worked on at a time. Add, remove, peek and the unused
// codes pass from an execute state to a finish state that loads their result,
// and the next transaction is accepted once the controller is back in idle.
// Squash inserts a count state between the two that counts one group of eight
// queue entries per step, because the squash count walks the cleared-entry
// mask eight bits per cycle. Reset is asynchronous and leaves the queue empty
// with all per-thread counts at zero. A new transaction is accepted while the
// previous result still waits in the output register; the block only holds its
// next result back until out_stall falls.
module thread_tagged_inst_fifo_squash
    import ttifq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic [ID_W-1:0]   inst_id,
    input  logic              inst_present,
    input  logic [THR_W-1:0]  thread_sel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CNT_W-1:0]  occupancy,
    output logic [ID_W-1:0]   head_id,
    output logic              head_present,
    output logic [THR_W-1:0]  head_thread,
    output logic [CNT_W-1:0]  squashed_count,
    output logic [CNT_W-1:0]  thread_count,
    output logic              error
);

    // The controller sequences each transaction; the datapath owns all
    // queue state and the output register.
    ttifq_cmd_t cmd;
    ttifq_sts_t sts;

    ttifq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttifq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .inst_id        (inst_id),
        .inst_present   (inst_present),
        .thread_sel     (thread_sel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .occupancy      (occupancy),
        .head_id        (head_id),
        .head_present   (head_present),
        .head_thread    (head_thread),
        .squashed_count (squashed_count),
        .thread_count   (thread_count),
        .error          (error)
    );

endmodule

### rtl/ttifq_chk.sv
// Port-level checker for the thread-tagged instruction queue, with its bind.
// Depends on ttifq_pkg; attaches to thread_tagged_inst_fifo_squash.
module ttifq_chk
    import ttifq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [CNT_W-1:0]  occupancy,
    input logic [ID_W-1:0]   head_id,
    input logic              head_present,
    input logic [THR_W-1:0]  head_thread,
    input logic [CNT_W-1:0]  squashed_count,
    input logic [CNT_W-1:0]  thread_count,
    input logic              error
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(head_id) &&
        $stable(occupancy) && $stable(error) && $stable(squashed_count) &&
        $stable(head_thread))
        else $error("result changed while stalled");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // One thread never holds more entries than the whole queue.
    a_thread_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> thread_count <= occupancy)
        else $error("thread count above occupancy");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> !head_present && squashed_count == '0)
        else $error("error result carries data");

    a_squashed_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !head_present |-> head_id == '0)
        else $error("id shown for a dead or missing entry");

endmodule

bind thread_tagged_inst_fifo_squash ttifq_chk #(.DEPTH(DEPTH)) u_ttifq_chk (.*);
